// ----- rtl/core/cwm_pkg.sv -----
package cwm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int PHASE_W   = 16;
	localparam int KIND_W    = 2;
	localparam int LEN_W     = 17;
	localparam int CFG_IDX_W = 1;
	localparam int COEF_W    = 16;
	localparam int WEIGHT_W  = 32;
	localparam int PROD_W    = SAMPLE_W + WEIGHT_W;
	localparam int ROUND_SH  = 30;
	localparam int DIV_STEPS = PHASE_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_KIND   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

	// window shapes
	localparam logic [KIND_W-1:0] KIND_HANN     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HAMMING  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BLACKMAN = 2'd2;

	// cosine table: full depth, stored as one quarter wave plus the end point
	localparam int COS_DEPTH   = 1024;
	localparam int COS_IDX_W   = $clog2(COS_DEPTH);
	localparam int COS_QTR     = COS_DEPTH / 4;
	localparam int COS_QIDX_W  = $clog2(COS_QTR + 1);
	localparam int COS_LOW_W   = COS_IDX_W - 2;
	localparam int COS_MAG_W   = SAMPLE_W - 1;

	localparam logic [63:0] Q30_ONE    = 64'd1073741824;
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12};

	typedef logic [COS_MAG_W-1:0] cos_mag_t;
	typedef cos_mag_t cos_qtr_t [COS_QTR+1];

	typedef struct packed {
		logic signed [COEF_W-1:0] a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic accept;
		logic div_step;
		logic cos_lookup;
		logic coef_mul;
		logic weight_sum;
		logic prod_mul;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	// unsigned long division, only used while the table is built
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		int          b;
		rem = '0;
		quo = '0;
		for (b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// cosine of u/2^32 turns, first quadrant, Q2.30, by truncated taylor series
	function automatic logic [63:0] cos_quadrant_q30(input logic [63:0] u);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		logic [63:0] m;
		int          i;
		x   = (u * TWO_PI_Q30) >> 32;
		x2  = (x * x) >> 30;
		acc = Q30_ONE;
		for (i = 0; i < 6; i++) begin
			acc = Q30_ONE - udiv64(x2 * acc, TAYLOR_DIV[i] << 30);
		end
		m = (x2 * acc) >> 31;
		return (m >= Q30_ONE) ? 64'd0 : Q30_ONE - m;
	endfunction

	function automatic cos_qtr_t build_cos_qtr();
		cos_qtr_t    tbl;
		logic [63:0] mag;
		int          j;
		for (j = 0; j <= COS_QTR; j++) begin
			mag = cos_quadrant_q30(64'(j) << (32 - COS_IDX_W));
			mag = (mag + 64'd16384) >> 15;
			if (mag > 64'd32767) begin
				mag = 64'd32767;
			end
			tbl[j] = mag[COS_MAG_W-1:0];
		end
		return tbl;
	endfunction

	localparam cos_qtr_t COS_QTR_TBL = build_cos_qtr();

	// signed Q1.15 cosine for a full-wave table index, folded onto the quarter wave
	function automatic logic signed [SAMPLE_W-1:0] cos_value(input logic [COS_IDX_W-1:0] idx);
		logic [1:0]            quad;
		logic [COS_LOW_W-1:0]  low;
		logic [COS_QIDX_W-1:0] j;
		logic [SAMPLE_W-1:0]   mag;
		quad = idx[COS_IDX_W-1 -: 2];
		low  = idx[COS_LOW_W-1:0];
		j    = quad[0] ? COS_QIDX_W'(COS_QTR) - COS_QIDX_W'(low) : COS_QIDX_W'(low);
		mag  = SAMPLE_W'(COS_QTR_TBL[j]);
		return (quad[1] ^ quad[0]) ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic coef_t kind_coef(input logic [KIND_W-1:0] kind);
		coef_t c;
		unique case (kind)
			KIND_HAMMING: begin
				c.a0 = 16'sd17695;
				c.a1 = 16'sd15073;
				c.a2 = 16'sd0;
			end
			KIND_BLACKMAN: begin
				c.a0 = 16'sd13763;
				c.a1 = 16'sd16384;
				c.a2 = 16'sd2621;
			end
			default: begin
				c.a0 = 16'sd16384;
				c.a1 = 16'sd16384;
				c.a2 = 16'sd0;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/cwm_in_if.sv -----
interface cwm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cwm_pkg::SAMPLE_W-1:0]  sample_in;

	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

// ----- rtl/core/cwm_out_if.sv -----
interface cwm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cwm_pkg::SAMPLE_W-1:0]  windowed_sample;
	logic                                 last_in_window;

	modport source(output valid, output windowed_sample, output last_in_window, input ready);
	modport sink(input valid, input windowed_sample, input last_in_window, output ready);
endinterface

// ----- rtl/core/cwm_ctrl.sv -----
module cwm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cwm_pkg::stat_t stat,
	output cwm_pkg::cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_COS  = 7'b0000100,
		ST_MUL  = 7'b0001000,
		ST_SUM  = 7'b0010000,
		ST_PROD = 7'b0100000,
		ST_RND  = 7'b1000000
	} state_t;

	state_t                        state_q;
	state_t                        state_d;
	logic [cwm_pkg::STEP_W-1:0]    step_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == cwm_pkg::STEP_W'(cwm_pkg::DIV_STEPS - 1)) begin
					state_d = ST_COS;
				end
			end
			ST_COS:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_PROD;
			ST_PROD: state_d = ST_RND;
			ST_RND: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.accept     = (state_q == ST_IDLE) && in_valid;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.cos_lookup = (state_q == ST_COS);
		cmd.coef_mul   = (state_q == ST_MUL);
		cmd.weight_sum = (state_q == ST_SUM);
		cmd.prod_mul   = (state_q == ST_PROD);
		cmd.load_out   = (state_q == ST_RND) && stat.out_free;
	end

endmodule

// ----- rtl/core/cwm_datapath.sv -----
module cwm_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cwm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cwm_pkg::LEN_W-1:0]             cfg_data,
	input  logic signed [cwm_pkg::SAMPLE_W-1:0]   sample_in,
	input  cwm_pkg::cmd_t                         cmd,
	output cwm_pkg::stat_t                        stat,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [cwm_pkg::SAMPLE_W-1:0]   windowed_sample,
	output logic                                  last_in_window
);

	localparam int SW = cwm_pkg::SAMPLE_W;
	localparam int PW = cwm_pkg::PHASE_W;
	localparam int WW = cwm_pkg::WEIGHT_W;
	localparam int RW = cwm_pkg::PROD_W - cwm_pkg::ROUND_SH;

	logic [cwm_pkg::KIND_W-1:0]     kind_q;
	logic [cwm_pkg::LEN_W-1:0]      len_q;
	logic [PW-1:0]                  pos_q;
	logic [PW-1:0]                  span;
	logic                           at_end;

	logic [PW-1:0]                  span_q;
	logic [PW-1:0]                  rem_q;
	logic [PW-1:0]                  quo_q;
	logic                           last_q;
	logic signed [SW-1:0]           sample_q;
	logic [PW:0]                    rem_dbl;
	logic                           rem_ge;

	logic signed [SW-1:0]           c1_q;
	logic signed [SW-1:0]           c2_q;
	logic signed [WW-1:0]           t1_q;
	logic signed [WW-1:0]           t2_q;
	logic signed [WW-1:0]           w_q;
	logic signed [cwm_pkg::PROD_W-1:0] prod_q;
	logic signed [cwm_pkg::PROD_W-1:0] prod_rnd;
	logic signed [RW-1:0]           res_wide;
	logic signed [SW-1:0]           res_sat;
	cwm_pkg::coef_t                 coef;

	logic                           out_valid_q;
	logic signed [SW-1:0]           out_sample_q;
	logic                           out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= cwm_pkg::KIND_HANN;
			len_q  <= cwm_pkg::LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cwm_pkg::REG_WINDOW_KIND:   kind_q <= cfg_data[cwm_pkg::KIND_W-1:0];
				cwm_pkg::REG_WINDOW_LENGTH: len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// length clamped to 2..65536, span is length minus one
	always_comb begin
		if (len_q < cwm_pkg::LEN_W'(2)) begin
			span = PW'(1);
		end else if (len_q[cwm_pkg::LEN_W-1]) begin
			span = '1;
		end else begin
			span = len_q[PW-1:0] - 1'b1;
		end
	end

	assign at_end = (pos_q >= span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.accept) begin
			pos_q <= at_end ? '0 : pos_q + 1'b1;
		end
	end

	// restoring divider, one quotient bit a step; last position gives phase zero
	assign rem_dbl = {rem_q, 1'b0};
	assign rem_ge  = (rem_dbl >= {1'b0, span_q});

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			span_q   <= span;
			rem_q    <= at_end ? '0 : pos_q;
			quo_q    <= '0;
			last_q   <= at_end;
			sample_q <= sample_in;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? PW'(rem_dbl - {1'b0, span_q}) : rem_dbl[PW-1:0];
			quo_q <= {quo_q[PW-2:0], rem_ge};
		end
	end

	assign coef = cwm_pkg::kind_coef(kind_q);

	always_ff @(posedge clk) begin
		if (cmd.cos_lookup) begin
			c1_q <= cwm_pkg::cos_value(quo_q[PW-1 -: cwm_pkg::COS_IDX_W]);
			c2_q <= cwm_pkg::cos_value(quo_q[PW-2 -: cwm_pkg::COS_IDX_W]);
		end
		if (cmd.coef_mul) begin
			t1_q <= WW'(coef.a1) * WW'(c1_q);
			t2_q <= WW'(coef.a2) * WW'(c2_q);
		end
		if (cmd.weight_sum) begin
			w_q <= $signed({2'b0, coef.a0[SW-2:0], 15'b0}) - t1_q + t2_q;
		end
		if (cmd.prod_mul) begin
			prod_q <= cwm_pkg::PROD_W'(sample_q) * cwm_pkg::PROD_W'(w_q);
		end
	end

	// round half up then saturate
	assign prod_rnd = prod_q + cwm_pkg::PROD_W'(64'd1 << (cwm_pkg::ROUND_SH - 1));
	assign res_wide = prod_rnd[cwm_pkg::PROD_W-1:cwm_pkg::ROUND_SH];

	always_comb begin
		if (res_wide > RW'(signed'(32'sd32767))) begin
			res_sat = {1'b0, {(SW-1){1'b1}}};
		end else if (res_wide < RW'(-32'sd32768)) begin
			res_sat = {1'b1, {(SW-1){1'b0}}};
		end else begin
			res_sat = res_wide[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_sample_q <= res_sat;
			out_last_q   <= last_q;
		end
	end

	assign stat.out_free   = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign windowed_sample = out_sample_q;
	assign last_in_window  = out_last_q;

endmodule

// ----- rtl/core/cosine_window_multiplier.sv -----
// channel  | dir | word                              | notes
// in_ch    | in  | sample_in (signed q1.15)          | valid/ready, one sample a word
// out_ch   | out | windowed_sample, last_in_window   | valid/ready, held in output register
// cfg      | in  | cfg_we, cfg_index, cfg_data       | write only, 0 kind, 1 length
//
// per word: an accept step, 16 divider steps for the phase
// (position * 65536 / (length - 1)), then cosine lookup, coefficient multiply,
// weight sum, sample multiply and round/saturate, in that order.
// a single restoring divider serves each word in turn; a full output register
// holds the sequencer in its last step until the word is taken.
// async active-low reset: kind hann, length 1024, position zero, channels empty.
module cosine_window_multiplier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cwm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cwm_pkg::LEN_W-1:0]     cfg_data,
	cwm_in_if.sink                        in_ch,
	cwm_out_if.source                     out_ch
);

	cwm_pkg::cmd_t  cmd;
	cwm_pkg::stat_t stat;

	// sequencer: idle, divide, lookup, multiply, sum, product, round
	cwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// config registers, position counter, divider, table, multipliers, output register
	cwm_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample_in       (in_ch.sample_in),
		.cmd             (cmd),
		.stat            (stat),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.windowed_sample (out_ch.windowed_sample),
		.last_in_window  (out_ch.last_in_window)
	);

endmodule

// ----- rtl/core/cwm_checker.sv -----
module cwm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [cwm_pkg::SAMPLE_W-1:0] windowed_sample,
	input logic                                last_in_window
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(windowed_sample)
			&& $stable(last_in_window))
		else $error("output word changed while stalled");

	// one word in flight: no accept straight after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accept");

	// ready only drops because a word was taken
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("input ready dropped with no word offered");

	// a result appears only from the busy sequence
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind cosine_window_multiplier cwm_checker u_cwm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.windowed_sample (out_ch.windowed_sample),
	.last_in_window  (out_ch.last_in_window)
);

// ----- test/tb_cosine_window_multiplier.sv -----
`timescale 1ns / 1ps

module tb_cosine_window_multiplier;

	localparam int SW          = cwm_pkg::SAMPLE_W;
	localparam int KW          = cwm_pkg::KIND_W;
	localparam int LW          = cwm_pkg::LEN_W;
	localparam int IW          = cwm_pkg::CFG_IDX_W;
	// full cosine wave as the block sees it, indexed by the top bits of the phase
	localparam int COS_ENTRIES = 1024;
	localparam int IDX_SHIFT   = 6;
	localparam logic [63:0] UNITY_Q30 = 64'd1073741824;
	localparam logic [63:0] TURN_Q30  = 64'd6746518852;
	localparam longint SAT_HI  = 32767;
	localparam longint SAT_LO  = -32768;
	// no handshake on either side for this many cycles means the block is stuck
	localparam int IDLE_LIMIT  = 2000;
	// settling wait at the end, with margin for the output register
	localparam int SETTLE      = 40;
	localparam int RANDOM_WORDS = 800;

	typedef struct {
		logic signed [SW-1:0] windowed;
		logic                 last;
	} windowed_word_t;

	class window_scoreboard;
		logic [KW-1:0]        kind;
		logic [LW-1:0]        length;
		logic [15:0]          position;
		logic signed [SW-1:0] cos_rom [COS_ENTRIES];
		windowed_word_t       expected_words [$];
		int                   errors;

		// first-quadrant cosine of u/2^32 turns in q2.30, truncated taylor series
		function logic [63:0] quarter_cos_q30(input logic [63:0] u);
			logic [63:0] x;
			logic [63:0] x2;
			logic [63:0] acc;
			logic [63:0] m;
			int unsigned dv [6];
			int          i;
			dv  = '{182, 132, 90, 56, 30, 12};
			x   = (u * TURN_Q30) >> 32;
			x2  = (x * x) >> 30;
			acc = UNITY_Q30;
			for (i = 0; i < 6; i++) begin
				acc = UNITY_Q30 - (x2 * acc) / (64'(dv[i]) << 30);
			end
			m = (x2 * acc) >> 31;
			return (m >= UNITY_Q30) ? 64'd0 : UNITY_Q30 - m;
		endfunction

		function new();
			logic [63:0] t;
			logic [63:0] f;
			logic [63:0] mag;
			logic        neg;
			int          k;
			kind     = cwm_pkg::KIND_HANN;
			length   = cwm_pkg::LEN_RESET;
			position = '0;
			errors   = 0;
			for (k = 0; k < COS_ENTRIES; k++) begin
				t = (64'(k) << 32) / COS_ENTRIES;
				f = t & (UNITY_Q30 - 1);
				case (t[31:30])
					2'd0: begin
						mag = quarter_cos_q30(f);
						neg = 1'b0;
					end
					2'd1: begin
						mag = quarter_cos_q30(UNITY_Q30 - f);
						neg = 1'b1;
					end
					2'd2: begin
						mag = quarter_cos_q30(f);
						neg = 1'b1;
					end
					default: begin
						mag = quarter_cos_q30(UNITY_Q30 - f);
						neg = 1'b0;
					end
				endcase
				mag = (mag + 64'd16384) >> 15;
				if (mag > 64'd32767)
					mag = 64'd32767;
				cos_rom[k] = neg ? -$signed(SW'(mag)) : $signed(SW'(mag));
			end
		endfunction

		function void write_reg(input logic [IW-1:0] idx, input logic [LW-1:0] data);
			if (idx == cwm_pkg::REG_WINDOW_KIND)
				kind = data[KW-1:0];
			else if (idx == cwm_pkg::REG_WINDOW_LENGTH)
				length = data;
		endfunction

		function void note_sample(input logic signed [SW-1:0] s);
			logic [LW-1:0]  len_eff;
			logic [LW-1:0]  span;
			logic [LW-1:0]  n;
			logic [63:0]    quot;
			logic [15:0]    phase;
			logic [15:0]    phase2;
			longint         a0;
			longint         a1;
			longint         a2;
			longint         w;
			longint         prod;
			longint         r;
			windowed_word_t word;
			// lengths out of range are clamped to 2..65536
			len_eff = length;
			if (len_eff < LW'(2))
				len_eff = LW'(2);
			if (len_eff > LW'(65536))
				len_eff = LW'(65536);
			span = len_eff - LW'(1);
			// a position past the end (length cut mid-window) counts as the last one
			n         = LW'(position);
			word.last = (n >= span);
			if (n > span)
				n = span;
			quot   = (64'(n) << 16) / 64'(span);
			phase  = quot[15:0];
			phase2 = {phase[14:0], 1'b0};
			case (kind)
				cwm_pkg::KIND_HAMMING: begin
					a0 = 17695;
					a1 = 15073;
					a2 = 0;
				end
				cwm_pkg::KIND_BLACKMAN: begin
					a0 = 13763;
					a1 = 16384;
					a2 = 2621;
				end
				default: begin
					a0 = 16384;
					a1 = 16384;
					a2 = 0;
				end
			endcase
			w = a0 * 32768 - a1 * longint'(cos_rom[phase[15:IDX_SHIFT]])
				+ a2 * longint'(cos_rom[phase2[15:IDX_SHIFT]]);
			prod = longint'(s) * w;
			// round half up to q1.15, then saturate
			r = (prod + (longint'(1) <<< 29)) >>> 30;
			if (r > SAT_HI)
				r = SAT_HI;
			if (r < SAT_LO)
				r = SAT_LO;
			word.windowed = r[SW-1:0];
			expected_words.push_back(word);
			position = word.last ? 16'd0 : 16'(n + 1);
		endfunction

		function void check_result(input logic signed [SW-1:0] ws, input logic last);
			windowed_word_t word;
			if (expected_words.size() == 0) begin
				$error("unexpected windowed word: windowed_sample %0d last_in_window %0b",
					ws, last);
				errors++;
				return;
			end
			word = expected_words.pop_front();
			if (ws !== word.windowed) begin
				$error("windowed_sample: expected %0d, got %0d", word.windowed, ws);
				errors++;
			end
			if (last !== word.last) begin
				$error("last_in_window: expected %0b, got %0b", word.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [IW-1:0] cfg_index;
	logic [LW-1:0] cfg_data;

	cwm_in_if  in_ch();
	cwm_out_if out_ch();

	cosine_window_multiplier DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	window_scoreboard sb = new();

	// sender burst control and receiver stall pattern
	int gap_max;
	int burst_left;
	int words_sent;
	bit rx_free;
	bit rx_level;
	int rx_hold;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: ready held high or low for random stretches, or always high
	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_level = rx_free || ($urandom_range(0, 2) != 0);
			rx_hold  = rx_level ? $urandom_range(1, 20) : $urandom_range(1, 25);
		end else begin
			rx_hold--;
		end
		out_ch.ready <= rx_level;
	end

	// monitor: note accepted samples, check windowed words, watch for a hang
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			sb.note_sample(in_ch.sample_in);
		if (out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.windowed_sample, out_ch.last_in_window);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [IW-1:0] idx, input logic [LW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// registers only change once every windowed word has come back
	task automatic program_window(input logic [KW-1:0] kind, input logic [LW-1:0] len);
		wait_drained();
		write_reg(cwm_pkg::REG_WINDOW_KIND, LW'(kind));
		write_reg(cwm_pkg::REG_WINDOW_LENGTH, len);
	endtask

	task automatic pick_idling();
		gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(4, 40);
		burst_left = 0;
		rx_free    = ($urandom_range(0, 3) == 0);
	endtask

	// one sample word; valid stays high across a burst, drops for a random gap after it
	task automatic send_sample(input logic signed [SW-1:0] s);
		if (gap_max > 0 && burst_left <= 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		in_ch.valid     <= 1'b1;
		in_ch.sample_in <= s;
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
		words_sent++;
	endtask

	function automatic logic signed [SW-1:0] corner_sample(input int i);
		case (i % 8)
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'sh0001;
			4: return 16'shffff;
			5: return 16'sh4000;
			6: return 16'shc000;
			default: return 16'sh3039;
		endcase
	endfunction

	// a run of samples: corners cycled in the directed part, mostly random later
	task automatic send_run(input int count, input bit directed);
		int i;
		logic signed [SW-1:0] s;
		for (i = 0; i < count; i++) begin
			if (directed || $urandom_range(0, 7) == 0)
				s = corner_sample(directed ? i : $urandom_range(0, 7));
			else
				s = SW'($urandom);
			send_sample(s);
		end
		in_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [KW-1:0] kind;
		logic [LW-1:0] len;
		int            pick;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.sample_in = '0;
		out_ch.ready    = 1'b0;
		gap_max         = 0;
		burst_left      = 0;
		words_sent      = 0;
		rx_free         = 1'b1;
		rx_level        = 1'b1;
		rx_hold         = 0;
		idle_cycles     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: hann over 1024, start of the window
		pick_idling();
		send_run(5, 1'b1);
		// length cut to 3 mid-window: position 5 is past the end, so last and wrap;
		// unused kind code behaves as hann; position 1 hits the half-turn phase
		pick_idling();
		program_window(2'd3, 17'd3);
		send_run(4, 1'b1);
		// zero and one both behave as length two
		pick_idling();
		program_window(cwm_pkg::KIND_HAMMING, 17'd0);
		send_run(3, 1'b1);
		pick_idling();
		program_window(cwm_pkg::KIND_BLACKMAN, 17'd1);
		send_run(2, 1'b1);
		// all-ones length clamps to 65536
		pick_idling();
		program_window(cwm_pkg::KIND_BLACKMAN, 17'h1ffff);
		send_run(3, 1'b1);
		pick_idling();
		program_window(cwm_pkg::KIND_HAMMING, 17'd65536);
		send_run(2, 1'b1);
		pick_idling();
		program_window(cwm_pkg::KIND_BLACKMAN, 17'd5);
		send_run(5, 1'b1);

		// random phases, mostly short windows so the wrap comes often
		pick = words_sent;
		while (words_sent < pick + RANDOM_WORDS) begin
			kind = KW'($urandom_range(0, 3));
			case ($urandom_range(0, 99)) inside
				[0:69]:  len = LW'($urandom_range(2, 48));
				[70:87]: len = LW'($urandom_range(49, 2048));
				[88:92]: len = LW'($urandom_range(0, 1));
				[93:96]: len = 17'd65536;
				default: len = LW'($urandom_range(65537, 131071));
			endcase
			pick_idling();
			program_window(kind, len);
			send_run($urandom_range(5, 60), 1'b0);
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
